// ===== hw/rtl/tacho_pkg.sv =====
// Shared constants and types for the wheel tachometer.
// Used by tacho_div and wheel_tachometer_period_rpm_top.
`timescale 1ns / 1ps
`default_nettype none

package tacho_pkg;

	localparam int COUNT_BITS   = 24;
	localparam int PULSE_BITS   = 31;
	localparam int DIV_CNT_BITS = $clog2(COUNT_BITS);
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RPM_NUM = 1'd1;

	localparam logic [COUNT_BITS-1:0] TIMEOUT_RESET = 24'd1000000;
	localparam logic [COUNT_BITS-1:0] RPM_NUM_RESET = 24'd7500000;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [PULSE_BITS-1:0] PULSE_MAX = {PULSE_BITS{1'b1}};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD
	} tacho_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tacho_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on tacho_pkg for the operand width.
`timescale 1ns / 1ps
`default_nettype none

module tacho_div
	import tacho_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire  [COUNT_BITS-1:0] dividend,
	input  wire  [COUNT_BITS-1:0] divisor,
	output logic                  done,
	output logic [COUNT_BITS-1:0] quotient
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [COUNT_BITS-1:0]   dvd_q;
	logic [COUNT_BITS-1:0]   dvs_q;
	logic [COUNT_BITS:0]     shifted;
	logic [COUNT_BITS:0]     diff;
	logic                    qbit;

	assign shifted = {rem_q, dvd_q[COUNT_BITS-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign qbit    = ~diff[COUNT_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(COUNT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// advance one digit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
			dvd_q <= {dvd_q[COUNT_BITS-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wheel_tachometer_period_rpm_top.sv =====
// Wheel tachometer top level: tick counting, period and rpm, standstill timeout, pulse count.
// Depends on tacho_pkg and tacho_div.
`timescale 1ns / 1ps
`default_nettype none

// Each input word is one timebase tick and yields one output word. A tick
// without an edge, or the first edge after standstill, is registered to the
// output without the divider. An edge while rotating takes a fresh period and
// runs the serial divider, one quotient bit per cycle: the word leaves once the
// divider is done and the output is free, and no new tick is taken until then.
// Configuration writes are always ready and must be made while idle.
module wheel_tachometer_period_rpm_top
	import tacho_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_stall,
	input  wire                     edge_seen,
	input  wire                     clear_path,
	output logic                    out_valid,
	input  wire                     out_stall,
	output logic                    rotating,
	output logic [COUNT_BITS-1:0]   period_ticks,
	output logic [COUNT_BITS-1:0]   speed_rpm,
	output logic [PULSE_BITS-1:0]   pulse_total,
	output logic                    new_period,
	input  wire                     cfg_valid,
	output logic                    cfg_ready,
	input  wire  [CFG_IDX_BITS-1:0] cfg_index,
	input  wire  [COUNT_BITS-1:0]   cfg_data
);

	tacho_state_t state_q, state_d;

	logic [COUNT_BITS-1:0] timeout_q;
	logic [COUNT_BITS-1:0] rpm_num_q;

	logic                  moving_q;
	logic [COUNT_BITS-1:0] ticks_q;
	logic [COUNT_BITS-1:0] period_q;
	logic [COUNT_BITS-1:0] speed_q;
	logic [PULSE_BITS-1:0] pulse_q;

	logic                  out_valid_q;
	logic                  rotating_q;
	logic [COUNT_BITS-1:0] period_out_q;
	logic [COUNT_BITS-1:0] speed_out_q;
	logic [PULSE_BITS-1:0] pulse_out_q;
	logic                  new_period_q;

	logic                  out_free;
	logic                  accept;
	logic                  div_start;
	logic                  load_div;
	logic                  div_done;
	logic [COUNT_BITS-1:0] quotient;

	logic [COUNT_BITS-1:0] ticks_inc;
	logic [COUNT_BITS-1:0] period_edge;
	logic [PULSE_BITS-1:0] pulse_base;
	logic [PULSE_BITS-1:0] pulse_d;
	logic                  moving_d;
	logic [COUNT_BITS-1:0] ticks_d;
	logic [COUNT_BITS-1:0] period_d;
	logic [COUNT_BITS-1:0] speed_d;
	logic                  fresh_d;

	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && out_free && edge_seen && moving_q) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		load_div  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = !out_free;
				div_start = in_valid && out_free && edge_seen && moving_q;
			end
			ST_LOAD: load_div = out_free;
			default: ;
		endcase
	end

	assign accept = in_valid && !in_stall;

	always_comb begin
		ticks_inc   = (ticks_q == COUNT_MAX) ? ticks_q : ticks_q + 1'b1;
		period_edge = moving_q ? ticks_inc : '0;
		pulse_base  = clear_path ? '0 : pulse_q;
		pulse_d     = (edge_seen && pulse_base != PULSE_MAX) ? pulse_base + 1'b1 : pulse_base;
		if (edge_seen) begin
			moving_d = 1'b1;
			ticks_d  = '0;
			period_d = period_edge;
			speed_d  = '0;
			fresh_d  = moving_q;
		end else begin
			moving_d = moving_q && (ticks_inc < timeout_q);
			ticks_d  = ticks_inc;
			period_d = period_q;
			speed_d  = speed_q;
			fresh_d  = 1'b0;
		end
	end

	tacho_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rpm_num_q),
		.divisor  (period_edge),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			timeout_q   <= TIMEOUT_RESET;
			rpm_num_q   <= RPM_NUM_RESET;
			moving_q    <= 1'b0;
			ticks_q     <= '0;
			period_q    <= '0;
			speed_q     <= '0;
			pulse_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_RPM_NUM: rpm_num_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				moving_q <= moving_d;
				ticks_q  <= ticks_d;
				period_q <= period_d;
				speed_q  <= speed_d;
				pulse_q  <= pulse_d;
			end
			if (load_div) begin
				speed_q <= quotient;
			end
			if (accept && !div_start || load_div) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the output word until taken
	always_ff @(posedge clk) begin
		if (accept && !div_start) begin
			rotating_q   <= moving_d;
			period_out_q <= period_d;
			speed_out_q  <= moving_d ? speed_d : '0;
			pulse_out_q  <= pulse_d;
			new_period_q <= fresh_d;
		end else if (load_div) begin
			rotating_q   <= moving_q;
			period_out_q <= period_q;
			speed_out_q  <= quotient;
			pulse_out_q  <= pulse_q;
			new_period_q <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign rotating     = rotating_q;
	assign period_ticks = period_out_q;
	assign speed_rpm    = speed_out_q;
	assign pulse_total  = pulse_out_q;
	assign new_period   = new_period_q;

endmodule

`default_nettype wire
